### rtl/mecs_pkg.sv
// ----------------------------------------------------------------------------
// mecs_pkg
// Shared types, constants and helpers of the minimum entropy cell selector.
// ----------------------------------------------------------------------------
package mecs_pkg;

   localparam int WEIGHT_W  = 16;
   localparam int JITTER_W  = 11;
   localparam int WSUM_W    = 24;
   localparam int TSUM_W    = 40;
   localparam int ENT_W     = 24;
   localparam int MIN_W     = 25;
   localparam int CELL_W    = 12;
   localparam int FRAC_W    = 20;
   localparam int MANT_W    = 31;
   localparam int LN_W      = 25;
   localparam int DIVD_W    = 49;

   localparam logic [31:0]        LN2_Q32   = 32'd2977044472;
   localparam logic [MIN_W-1:0]   MIN_RESET = '1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LOG_NORM,
      ST_LOG_SQ,
      ST_LN_MUL,
      ST_LN_RND,
      ST_TERM_MUL,
      ST_TERM_ACC,
      ST_CHECK,
      ST_DIV_LOAD,
      ST_DIV,
      ST_H_CALC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic set_skip;
      logic log_norm;
      logic log_src_sum;
      logic log_step;
      logic ln_mul;
      logic ln_rnd;
      logic term_mul;
      logic term_acc;
      logic div_load;
      logic div_step;
      logic h_calc;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic weight_nz;
      logic cell_end;
      logic selectable;
      logic log_last;
      logic div_last;
      logic out_busy;
   } status_type;

   // MSB position of a nonzero 24-bit value (0 for zero)
   function automatic logic [4:0] msb_index(input logic [WSUM_W-1:0] v);
      logic [4:0] e;
      e = 5'd0;
      for (int i = 0; i < WSUM_W; i++) begin
         if (v[i]) begin
            e = 5'(i);
         end
      end
      return e;
   endfunction

endpackage

### rtl/mecs_ctrl.sv
// ----------------------------------------------------------------------------
// mecs_ctrl
// Sequencer: walks one beat through log, term, divide and compare steps.
// ----------------------------------------------------------------------------
module mecs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  mecs_pkg::status_type  status,
   output mecs_pkg::cmd_type     cmd
);

   mecs_pkg::state_type state_ff, state_in;
   logic                sum_mode_ff, sum_mode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= mecs_pkg::ST_IDLE;
         sum_mode_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sum_mode_ff <= sum_mode_in;
      end
   end

   // next state
   always_comb begin
      state_in    = state_ff;
      sum_mode_in = sum_mode_ff;
      case (state_ff)
         mecs_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = mecs_pkg::ST_DECODE;
         end
         mecs_pkg::ST_DECODE: begin
            sum_mode_in = 1'b0;
            if (status.skip)           state_in = mecs_pkg::ST_CHECK;
            else if (status.weight_nz) state_in = mecs_pkg::ST_LOG_NORM;
            else                       state_in = mecs_pkg::ST_CHECK;
         end
         mecs_pkg::ST_LOG_NORM: state_in = mecs_pkg::ST_LOG_SQ;
         mecs_pkg::ST_LOG_SQ: begin
            if (status.log_last) state_in = mecs_pkg::ST_LN_MUL;
         end
         mecs_pkg::ST_LN_MUL: state_in = mecs_pkg::ST_LN_RND;
         mecs_pkg::ST_LN_RND: begin
            state_in = sum_mode_ff ? mecs_pkg::ST_DIV_LOAD : mecs_pkg::ST_TERM_MUL;
         end
         mecs_pkg::ST_TERM_MUL: state_in = mecs_pkg::ST_TERM_ACC;
         mecs_pkg::ST_TERM_ACC: state_in = mecs_pkg::ST_CHECK;
         mecs_pkg::ST_CHECK: begin
            if (!status.cell_end) begin
               state_in = mecs_pkg::ST_IDLE;
            end else if (status.selectable) begin
               state_in    = mecs_pkg::ST_LOG_NORM;
               sum_mode_in = 1'b1;
            end else begin
               state_in = mecs_pkg::ST_FINISH;
            end
         end
         mecs_pkg::ST_DIV_LOAD: state_in = mecs_pkg::ST_DIV;
         mecs_pkg::ST_DIV: begin
            if (status.div_last) state_in = mecs_pkg::ST_H_CALC;
         end
         mecs_pkg::ST_H_CALC: state_in = mecs_pkg::ST_FINISH;
         mecs_pkg::ST_FINISH: begin
            if (!status.out_busy) state_in = mecs_pkg::ST_IDLE;
         end
         default: state_in = mecs_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      cmd.log_src_sum = sum_mode_ff;
      case (state_ff)
         mecs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         mecs_pkg::ST_DECODE:   cmd.set_skip = status.skip;
         mecs_pkg::ST_LOG_NORM: cmd.log_norm = 1'b1;
         mecs_pkg::ST_LOG_SQ:   cmd.log_step = 1'b1;
         mecs_pkg::ST_LN_MUL:   cmd.ln_mul   = 1'b1;
         mecs_pkg::ST_LN_RND:   cmd.ln_rnd   = 1'b1;
         mecs_pkg::ST_TERM_MUL: cmd.term_mul = 1'b1;
         mecs_pkg::ST_TERM_ACC: cmd.term_acc = 1'b1;
         mecs_pkg::ST_CHECK: begin
            cmd.log_src_sum = 1'b1;
         end
         mecs_pkg::ST_DIV_LOAD: cmd.div_load = 1'b1;
         mecs_pkg::ST_DIV:      cmd.div_step = 1'b1;
         mecs_pkg::ST_H_CALC:   cmd.h_calc   = 1'b1;
         mecs_pkg::ST_FINISH:   cmd.finish   = !status.out_busy;
         default: ;
      endcase
   end

endmodule

### rtl/mecs_datapath.sv
// ----------------------------------------------------------------------------
// mecs_datapath
// Accumulators, log2/ln unit, serial divider, minimum search, result register.
// ----------------------------------------------------------------------------
module mecs_datapath #(
   parameter int MAX_CELLS = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mecs_pkg::cmd_type     cmd,
   output mecs_pkg::status_type  status,
   input  logic [31:0]           req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [47:0]           rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int W  = mecs_pkg::WSUM_W;
   localparam int TW = mecs_pkg::TSUM_W;

   // latched beat
   logic [mecs_pkg::WEIGHT_W-1:0] w_ff;
   logic                          skip_ff, cell_end_ff, grid_end_ff;
   logic [mecs_pkg::JITTER_W-1:0] jit_ff;

   // cell / grid state
   logic [W-1:0]                  wsum_ff;
   logic signed [TW-1:0]          tsum_ff;
   logic                          skip_seen_ff;
   logic [mecs_pkg::CELL_W-1:0]   cnt_ff;
   logic [mecs_pkg::MIN_W-1:0]    min_ff;
   logic [mecs_pkg::CELL_W-1:0]   best_ff;
   logic                          found_ff;

   // log unit
   logic [mecs_pkg::MANT_W-1:0]   m_ff;
   logic [mecs_pkg::FRAC_W-1:0]   frac_ff;
   logic [4:0]                    exp_ff;
   logic [4:0]                    iter_ff;
   logic signed [58:0]            lnp_ff;
   logic signed [mecs_pkg::LN_W-1:0] ln_ff;
   logic signed [41:0]            tp_ff;

   // divider
   logic [W-1:0]                  rem_ff;
   logic [mecs_pkg::DIVD_W-1:0]   quo_ff;
   logic [5:0]                    dcnt_ff;
   logic                          neg_ff;
   logic [mecs_pkg::ENT_W-1:0]    h_ff;

   // result register
   logic                          ovalid_ff;
   logic [47:0]                   odata_ff;
   logic [1:0]                    ouser_ff;
   logic                          olast_ff;

   logic                          sel;
   assign sel = !skip_seen_ff && (wsum_ff != '0);

   assign status.skip       = skip_ff;
   assign status.weight_nz  = (w_ff != '0);
   assign status.cell_end   = cell_end_ff;
   assign status.selectable = sel;
   assign status.log_last   = (iter_ff == 5'd0);
   assign status.div_last   = (dcnt_ff == 6'd0);
   assign status.out_busy   = ovalid_ff && !rsp_tready;

   // log normalization
   logic [W-1:0]  log_v;
   logic [4:0]    log_e;
   logic [30:0]   log_m;
   assign log_v = cmd.log_src_sum ? wsum_ff : {8'd0, w_ff};
   assign log_e = mecs_pkg::msb_index(log_v);
   assign log_m = {7'd0, log_v} << (5'd30 - log_e);

   // squaring step
   logic [61:0] sq;
   logic [31:0] sq_hi;
   assign sq    = {31'd0, m_ff} * {31'd0, m_ff};
   assign sq_hi = sq[61:30];

   // ln = (log2 - 8) * ln2, rounded
   logic signed [25:0] d_val;
   logic signed [58:0] ln_rnd;
   assign d_val  = $signed({1'b0, exp_ff, frac_ff}) - 26'sd8388608;
   assign ln_rnd = lnp_ff + 59'sd2147483648;

   // term and accumulators
   logic signed [41:0] t_rnd;
   logic signed [TW:0] tacc;
   logic [W:0]         wacc;
   assign t_rnd = tp_ff + 42'sd128;
   assign tacc  = {tsum_ff[TW-1], tsum_ff} + {{7{t_rnd[41]}}, t_rnd[41:8]};
   assign wacc  = {1'b0, wsum_ff} + {9'd0, w_ff};

   // divider
   logic [TW-1:0]               mag;
   logic [W:0]                  dr;
   logic                        dbit;
   assign mag  = tsum_ff[TW-1] ? TW'(-tsum_ff) : TW'(tsum_ff);
   assign dr   = {rem_ff, quo_ff[mecs_pkg::DIVD_W-1]};
   assign dbit = (dr >= {1'b0, wsum_ff});

   // entropy
   logic signed [50:0] qs;
   logic signed [50:0] hw;
   assign qs = neg_ff ? -$signed({2'b0, quo_ff}) : $signed({2'b0, quo_ff});
   assign hw = {{26{ln_ff[mecs_pkg::LN_W-1]}}, ln_ff} - qs;

   // minimum search
   logic [mecs_pkg::ENT_W-1:0]  h_out;
   logic [mecs_pkg::MIN_W-1:0]  jv;
   logic                        upd;
   logic                        n_found;
   logic [mecs_pkg::CELL_W-1:0] n_best;
   logic [31:0]                 cnt_inc;
   assign h_out   = sel ? h_ff : '0;
   assign jv      = {1'b0, h_ff} + {14'd0, jit_ff};
   assign upd     = sel && (jv < min_ff);
   assign n_found = found_ff || upd;
   assign n_best  = upd ? cnt_ff : best_ff;
   assign cnt_inc = {20'd0, cnt_ff} + 32'd1;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         w_ff        <= req_tdata[15:0];
         jit_ff      <= req_tdata[26:16];
         skip_ff     <= req_tuser[0];
         grid_end_ff <= req_tuser[1];
         cell_end_ff <= req_tlast || req_tuser[1];
      end
      if (cmd.log_norm) begin
         m_ff    <= log_m;
         exp_ff  <= log_e;
         frac_ff <= '0;
         iter_ff <= 5'd19;
      end
      if (cmd.log_step) begin
         if (sq_hi[31]) begin
            m_ff             <= sq_hi[31:1];
            frac_ff[iter_ff] <= 1'b1;
         end else begin
            m_ff <= sq_hi[30:0];
         end
         iter_ff <= iter_ff - 5'd1;
      end
      if (cmd.ln_mul) lnp_ff <= d_val * $signed({1'b0, mecs_pkg::LN2_Q32});
      if (cmd.ln_rnd) ln_ff  <= ln_rnd[56:32];
      if (cmd.term_mul) tp_ff <= $signed({1'b0, w_ff}) * ln_ff;
      if (cmd.div_load) begin
         neg_ff  <= tsum_ff[TW-1];
         quo_ff  <= {1'b0, mag, 8'd0} + {26'd0, wsum_ff[W-1:1]};
         rem_ff  <= '0;
         dcnt_ff <= 6'd48;
      end
      if (cmd.div_step) begin
         rem_ff  <= dbit ? W'(dr - {1'b0, wsum_ff}) : dr[W-1:0];
         quo_ff  <= {quo_ff[mecs_pkg::DIVD_W-2:0], dbit};
         dcnt_ff <= dcnt_ff - 6'd1;
      end
      if (cmd.h_calc) begin
         if (hw < 0)                      h_ff <= '0;
         else if (hw > 51'sd16777215)     h_ff <= '1;
         else                             h_ff <= hw[23:0];
      end
      if (cmd.finish) begin
         odata_ff <= {(n_found ? n_best : 12'd0), cnt_ff, h_out};
         ouser_ff <= {n_found, sel};
         olast_ff <= grid_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wsum_ff      <= '0;
         tsum_ff      <= '0;
         skip_seen_ff <= 1'b0;
         cnt_ff       <= '0;
         min_ff       <= mecs_pkg::MIN_RESET;
         best_ff      <= '0;
         found_ff     <= 1'b0;
         ovalid_ff    <= 1'b0;
      end else begin
         // new beat loads only when the held one is gone or leaving now
         ovalid_ff <= cmd.finish || (ovalid_ff && !rsp_tready);
         if (cmd.set_skip) skip_seen_ff <= 1'b1;
         if (cmd.term_acc) begin
            wsum_ff <= wacc[W] ? '1 : wacc[W-1:0];
            if (tacc > $signed({2'b00, {(TW-1){1'b1}}}))
               tsum_ff <= {1'b0, {(TW-1){1'b1}}};
            else if (tacc < $signed({2'b11, {(TW-1){1'b0}}}))
               tsum_ff <= {1'b1, {(TW-1){1'b0}}};
            else
               tsum_ff <= tacc[TW-1:0];
         end
         if (cmd.finish) begin
            wsum_ff      <= '0;
            tsum_ff      <= '0;
            skip_seen_ff <= 1'b0;
            if (grid_end_ff) begin
               cnt_ff   <= '0;
               min_ff   <= mecs_pkg::MIN_RESET;
               best_ff  <= '0;
               found_ff <= 1'b0;
            end else begin
               cnt_ff   <= (cnt_inc >= 32'(MAX_CELLS)) ? '0 : cnt_inc[11:0];
               found_ff <= n_found;
               best_ff  <= n_best;
               if (upd) min_ff <= jv;
            end
         end
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tuser  = ouser_ff;
   assign rsp_tlast  = olast_ff;

endmodule

### rtl/min_entropy_cell_select.sv
// ----------------------------------------------------------------------------
// min_entropy_cell_select
// Shannon entropy per grid cell from tile weights, minimum search over a grid.
// ----------------------------------------------------------------------------
// Steps: a zero or skipped weight is only decoded and checked; a nonzero weight
//   is decoded, takes log2 by squaring, then ln, then its term, then a check.
// A selectable cell end adds ln of the sum, a 49-step serial divide and the entropy.
// Throughput: one beat at a time; the shared log2 squarer, the divider and output back pressure set it.
// Reset: synchronous, active high; clears accumulators, cell counter, best cell.
// A result may wait in the output register while the next beat is accepted.
module min_entropy_cell_select #(
   parameter int MAX_CELLS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // weight[15:0], jitter[26:16], zero pad
   input  logic [1:0]  req_tuser,   // skip_cell[0], last_of_grid[1]
   input  logic        req_tlast,   // last_of_cell
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // cell_entropy[23:0], cell_number[35:24],
                                    // best_cell[47:36]
   output logic [1:0]  rsp_tuser,   // cell_selectable[0], best_found[1]
   output logic        rsp_tlast    // grid_done
);

   mecs_pkg::cmd_type    cmd;
   mecs_pkg::status_type status;

   // sequencer: one state per step of the beat's work; squaring and divide steps repeat in their state
   mecs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // arithmetic, grid state and result register
   mecs_datapath #(
      .MAX_CELLS (MAX_CELLS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for min_entropy_cell_select: random cells and grids of
// tile weights are streamed in, a local fixed-point entropy predictor builds
// the expected per-cell beats, and the monitor compares every result beat.
// ----------------------------------------------------------------------------
module tb;

   // input beat as the driver sees it
   typedef struct {
      logic [15:0] weight;
      logic        skip;
      logic        cell_end;
      logic        grid_end;
      logic [10:0] jitter;
   } tile_beat_type;

   // expected result beat
   typedef struct {
      logic [23:0] entropy;
      logic [11:0] number;
      logic        selectable;
      logic [11:0] best;
      logic        found;
      logic        done;
   } cell_result_type;

   localparam int   NUM_CELLS = 4096;
   localparam longint LN2     = 64'd2977044472;
   localparam longint T_MAX   = 64'sd549755813887;
   localparam longint T_MIN   = -64'sd549755813888;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   tile_beat_type   tile_queue[$];
   cell_result_type cell_results_due[$];
   int              mismatch_count;
   int              results_seen;
   int              grids_seen;
   int              selectable_seen;

   // predictor state
   logic [11:0]  cell_idx;
   logic [23:0]  wsum;
   longint       tsum;
   bit           skip_flag;
   logic [24:0]  min_h;
   logic [11:0]  best_idx;
   bit           found;

   min_entropy_cell_select DUT (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("tb: FAIL");
      $finish;
   end

   // arithmetic shift right with round half up
   function automatic longint shr_round(input longint p, input int sh);
      return (p + (64'sd1 <<< (sh - 1))) >>> sh;
   endfunction

   // log2 of v in Q.20, v in 1..2^24-1; mantissa squared per fraction bit
   function automatic longint log2_fix(input logic [23:0] v);
      int      e;
      longint  m;
      longint  frac;
      e = 23;
      frac = 0;
      while (e > 0 && v[e] == 1'b0) e--;
      m = longint'(v) << (30 - e);
      for (int i = 19; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (64'sd1 << 31)) begin
            m = m >> 1;
            frac |= 64'sd1 << i;
         end
      end
      return (longint'(e) << 20) | frac;
   endfunction

   // ln(v/256) in signed Q.20
   function automatic longint ln_fix(input logic [23:0] v);
      return shr_round((log2_fix(v) - (64'sd8 << 20)) * LN2, 32);
   endfunction

   task automatic predict_cell(input tile_beat_type t);
      cell_result_type r;
      longint          h;
      longint          mag;
      longint          q;
      logic [24:0]     jh;
      bit              sel;
      logic [24:0]     s;
      h = 0;
      if (t.skip) begin
         skip_flag = 1;
      end else if (t.weight != 0) begin
         s = wsum + t.weight;
         wsum = (s > 25'hFFFFFF) ? 24'hFFFFFF : s[23:0];
         tsum += shr_round(longint'(t.weight) * ln_fix({8'd0, t.weight}), 8);
         if (tsum > T_MAX) tsum = T_MAX;
         if (tsum < T_MIN) tsum = T_MIN;
      end
      if (!(t.cell_end || t.grid_end)) return;
      sel = !skip_flag && wsum != 0;
      if (sel) begin
         mag = (tsum < 0) ? -tsum : tsum;
         q = (mag * 256 + (wsum >> 1)) / wsum;
         h = ln_fix(wsum) - ((tsum < 0) ? -q : q);
         if (h < 0) h = 0;
         if (h > 64'hFFFFFF) h = 64'hFFFFFF;
         jh = 25'(h) + t.jitter;
         if (jh < min_h) begin
            min_h = jh;
            best_idx = cell_idx;
            found = 1;
         end
      end
      r.entropy = h[23:0];
      r.number = cell_idx;
      r.selectable = sel;
      r.best = found ? best_idx : 12'd0;
      r.found = found;
      r.done = t.grid_end;
      cell_results_due.push_back(r);
      wsum = 0;
      tsum = 0;
      skip_flag = 0;
      if (t.grid_end) begin
         cell_idx = 0;
         min_h = mecs_pkg::MIN_RESET;
         best_idx = 0;
         found = 0;
      end else begin
         cell_idx = (cell_idx == NUM_CELLS - 1) ? 12'd0 : cell_idx + 12'd1;
      end
   endtask

   task automatic drive_next();
      tile_beat_type t;
      t = tile_queue.pop_front();
      predict_cell(t);
      req_tdata  <= {5'd0, t.jitter, t.weight};
      req_tuser  <= {t.grid_end, t.skip};
      req_tlast  <= t.cell_end;
      req_tvalid <= 1'b1;
   endtask

   // beats taken at the last rising edge
   logic req_taken;
   logic rsp_taken;
   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
      rsp_taken <= rsp_tvalid && rsp_tready;
   end

   // driver: falling edge, random idle gap before each beat
   int gap_left;
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   <= $urandom_range(0, 7);
      end else if (req_tvalid && !req_taken) begin
         // beat still waiting, hold it
      end else if (gap_left > 0) begin
         req_tvalid <= 1'b0;
         gap_left   <= gap_left - 1;
      end else if (tile_queue.size() > 0) begin
         drive_next();
         gap_left <= $urandom_range(0, 7);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // receiver back pressure, random wait before each beat
   int stall_left;
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 7);
      end else if (rsp_tready && !rsp_taken) begin
         // ready, waiting for the next result beat
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= $urandom_range(0, 7);
      end
   end

   // monitor: compare every accepted result beat with the oldest expectation
   always @(posedge clock) begin
      cell_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tlast) grids_seen++;
         if (rsp_tuser[0]) selectable_seen++;
         if (cell_results_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result beat data=%h user=%b last=%b",
                        rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            e = cell_results_due.pop_front();
            if (rsp_tdata[23:0] !== e.entropy || rsp_tdata[35:24] !== e.number ||
                rsp_tdata[47:36] !== e.best || rsp_tuser[0] !== e.selectable ||
                rsp_tuser[1] !== e.found || rsp_tlast !== e.done) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch cell %0d: exp H=%h n=%0d sel=%b best=%0d fnd=%b done=%b",
                           e.number, e.entropy, e.number, e.selectable, e.best,
                           e.found, e.done, "\n         got H=%h n=%0d sel=%b best=%0d",
                           rsp_tdata[23:0], rsp_tdata[35:24], rsp_tuser[0],
                           rsp_tdata[47:36], " fnd=%b done=%b", rsp_tuser[1],
                           rsp_tlast);
            end
         end
      end
   end

   function automatic tile_beat_type mk(input logic [15:0] w, input bit sk,
                                        input bit ce, input bit ge,
                                        input logic [10:0] j);
      tile_beat_type t;
      t.weight = w; t.skip = sk; t.cell_end = ce; t.grid_end = ge; t.jitter = j;
      return t;
   endfunction

   // random weight: mostly moderate, some extremes and zeros
   function automatic logic [15:0] rand_weight();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'(1 << $urandom_range(0, 15));
         3: return 16'($urandom_range(1, 16));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int total;
      int tiles;
      int cells;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      cell_idx = 0; wsum = 0; tsum = 0; skip_flag = 0;
      min_h = mecs_pkg::MIN_RESET; best_idx = 0; found = 0;
      mismatch_count = 0; results_seen = 0; grids_seen = 0; selectable_seen = 0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: single weights at the extremes, zero-sum cell, skipped cell,
      // ties, jitter extremes, a cell of max weights, grid end without cell end
      tile_queue.push_back(mk(16'd1, 0, 1, 0, 11'd0));
      tile_queue.push_back(mk(16'hFFFF, 0, 1, 0, 11'd0));      // tie, no win
      tile_queue.push_back(mk(16'd0, 0, 1, 0, 11'd0));         // zero sum
      tile_queue.push_back(mk(16'd256, 0, 0, 0, 11'd5));
      tile_queue.push_back(mk(16'd256, 1, 1, 0, 11'd0));       // skipped
      tile_queue.push_back(mk(16'd1, 0, 0, 0, 11'd0));
      tile_queue.push_back(mk(16'hFFFF, 0, 1, 0, 11'h7FF));    // max jitter
      tile_queue.push_back(mk(16'd300, 0, 0, 0, 11'd0));
      tile_queue.push_back(mk(16'd300, 0, 1, 0, 11'd1048));
      tile_queue.push_back(mk(16'd512, 0, 0, 1, 11'd0));       // grid end only
      tile_queue.push_back(mk(16'd0, 1, 1, 1, 11'd0));         // empty grid
      for (int i = 0; i < 12; i++)                              // a cell of max weights
         tile_queue.push_back(mk(16'hFFFF, 0, i == 11, i == 11, 11'd3));
      total = tile_queue.size();

      // random grids of well-formed cells, with some noise
      while (total < 1600) begin
         cells = $urandom_range(1, 12);
         for (int c = 0; c < cells; c++) begin
            tiles = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 6);
            for (int k = 0; k < tiles; k++)
               tile_queue.push_back(mk(rand_weight(), $urandom_range(0, 19) == 0,
                                       k == tiles - 1 || $urandom_range(0, 49) == 0,
                                       c == cells - 1 && k == tiles - 1,
                                       11'($urandom_range(0, 15) == 0
                                           ? $urandom_range(0, 2047)
                                           : $urandom_range(0, 1048))));
            total += tiles;
         end
      end

      wait (tile_queue.size() == 0 && !req_tvalid);
      wait (cell_results_due.size() == 0);
      repeat (200) @(posedge clock);
      $display("tb: %0d tile beats, %0d cell results (%0d selectable), %0d grids",
               total, results_seen, selectable_seen, grids_seen);
      if (mismatch_count == 0 && cell_results_due.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

### sim.f
rtl/mecs_pkg.sv
rtl/mecs_ctrl.sv
rtl/mecs_datapath.sv
rtl/min_entropy_cell_select.sv
verif/tb.sv
